@@ rtl/dbff_pkg.sv @@
// shared types, constants and helper functions for the drone beacon frame filter
`default_nettype none

package dbff_pkg;

    localparam int SSID_ELEMENT_OFFSET = 36;
    localparam int ADDR2_OFFSET        = 10;
    localparam int ADDR_BYTES          = 6;
    localparam int MAX_FRAME_BYTES     = 4096;

    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MAC_W   = 8 * ADDR_BYTES;
    localparam int CNT_W   = 32;
    localparam int PHASE_W = 4;

    localparam logic [POS_W-1:0] FC0_POS      = POS_W'(0);
    localparam logic [POS_W-1:0] FC1_POS      = POS_W'(1);
    localparam logic [POS_W-1:0] ADDR2_FIRST  = POS_W'(ADDR2_OFFSET);
    localparam logic [POS_W-1:0] ADDR2_END    = POS_W'(ADDR2_OFFSET + ADDR_BYTES);
    localparam logic [POS_W-1:0] SSID_ID_POS  = POS_W'(SSID_ELEMENT_OFFSET);
    localparam logic [POS_W-1:0] SSID_LEN_POS = POS_W'(SSID_ELEMENT_OFFSET + 1);
    localparam logic [POS_W-1:0] SSID_BODY    = POS_W'(SSID_ELEMENT_OFFSET + 2);
    localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_FRAME_BYTES);

    localparam logic [7:0] FC0_MASK   = 8'hFC;
    localparam logic [7:0] FC0_BEACON = 8'h80;
    localparam logic [7:0] FC1_DS_MSK = 8'h03;

    localparam logic [PHASE_W-1:0] PREFIX_LEN = PHASE_W'(7);
    localparam logic [PHASE_W-1:0] MATCH_LEN  = PHASE_W'(14);
    localparam logic [PHASE_W-1:0] PHASE_IDLE = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       fcs_ok;
    } in_beat_t;

    typedef struct packed {
        logic             frame_good;
        logic             drone_beacon;
        logic [MAC_W-1:0] source_mac;
        logic             same_as_first;
        logic [CNT_W-1:0] frame_count;
        logic [CNT_W-1:0] good_count;
        logic [CNT_W-1:0] beacon_count;
    } out_beat_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "D";
            3'd1:    c = "r";
            3'd2:    c = "o";
            3'd3:    c = "n";
            3'd4:    c = "e";
            3'd5:    c = "4";
            3'd6:    c = "_";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || (c == "_");
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/drone_beacon_frame_filter.sv @@
// top level: per-byte beacon parser, drone ssid matcher, counters and result register
//
// Frame bytes are taken one per cycle on the frame channel while frame_ready is high,
// starting at frame control. Every byte updates the parser state in the same cycle it
// is accepted; the byte that carries last_byte produces one result beat, registered and
// shown on the next cycle, so the block sustains one byte per clock while not stalled.
// A single result register sits between the two sides: while a result waits,
// frame_ready stays high as long as result_ready is high, and drops only when the result
// register is full and not being drained. Bytes at position 4096 and beyond are ignored
// except for their last_byte and fcs_ok marks. No clearing pass is needed after reset.
`default_nettype none

module drone_beacon_frame_filter (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   frame_valid,
    output logic                  frame_ready,
    input  dbff_pkg::in_beat_t    frame_beat,
    output logic                  result_valid,
    input  wire                   result_ready,
    output dbff_pkg::out_beat_t   result_beat
);
    import dbff_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               fc_ok_reg, fc_ok_next;
    logic               id_zero_reg, id_zero_next;
    logic [7:0]         ssid_len_reg, ssid_len_next;
    logic               ssid_ended_reg, ssid_ended_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               found_reg, found_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [MAC_W-1:0]   first_mac_reg, first_mac_next;
    logic               first_valid_reg, first_valid_next;
    logic [CNT_W-1:0]   frames_reg, frames_next;
    logic [CNT_W-1:0]   good_reg, good_next;
    logic [CNT_W-1:0]   beacons_reg, beacons_next;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_beat_reg, out_beat_next;

    logic               accept;
    logic               end_beat;
    logic [7:0]         b;
    logic [POS_W-1:0]   body_ofs;
    logic               in_body;
    logic               drone;
    logic [MAC_W-1:0]   ref_mac;

    assign frame_ready  = !out_valid_reg || result_ready;
    assign accept       = frame_valid && frame_ready;
    assign end_beat     = accept && frame_beat.last_byte;
    assign b            = frame_beat.data_byte;
    assign body_ofs     = pos_reg - SSID_BODY;
    assign in_body      = (pos_reg >= SSID_BODY) && (body_ofs < POS_W'(ssid_len_reg));
    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        fc_ok_next      = fc_ok_reg;
        id_zero_next    = id_zero_reg;
        ssid_len_next   = ssid_len_reg;
        ssid_ended_next = ssid_ended_reg;
        phase_next      = phase_reg;
        found_next      = found_reg;
        mac_next        = mac_reg;

        if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + POS_W'(1);

            if (pos_reg == FC0_POS)
                fc_ok_next = (b & FC0_MASK) == FC0_BEACON;
            else if (pos_reg == FC1_POS)
                fc_ok_next = fc_ok_reg && ((b & FC1_DS_MSK) == 8'h00);

            if (pos_reg >= ADDR2_FIRST && pos_reg < ADDR2_END)
                mac_next = {mac_reg[MAC_W-9:0], b};

            if (pos_reg == SSID_ID_POS)
                id_zero_next = (b == 8'h00);
            else if (pos_reg == SSID_LEN_POS)
                ssid_len_next = b;
            else if (in_body && id_zero_reg && !ssid_ended_reg && !found_reg)
            begin
                if (b == 8'h00)
                    ssid_ended_next = 1'b1;
                else if (phase_reg < PREFIX_LEN)
                begin
                    if (b == prefix_char(phase_reg[2:0]))
                        phase_next = phase_reg + PHASE_W'(1);
                    else if (b == prefix_char(3'd0))
                        phase_next = PHASE_ONE;
                    else
                        phase_next = PHASE_IDLE;
                end
                else if (is_word(b))
                begin
                    if (phase_reg + PHASE_W'(1) >= MATCH_LEN)
                    begin
                        found_next = 1'b1;
                        phase_next = PHASE_IDLE;
                    end
                    else
                        phase_next = phase_reg + PHASE_W'(1);
                end
                else
                    phase_next = PHASE_IDLE;
            end
        end

        drone = frame_beat.fcs_ok && fc_ok_next && id_zero_next && found_next;
        ref_mac = first_valid_reg ? first_mac_reg : mac_next;

        first_mac_next   = first_mac_reg;
        first_valid_next = first_valid_reg;
        frames_next      = frames_reg;
        good_next        = good_reg;
        beacons_next     = beacons_reg;
        out_beat_next    = out_beat_reg;
        out_valid_next   = out_valid_reg && !result_ready;

        if (end_beat)
        begin
            frames_next = sat_inc(frames_reg);
            if (frame_beat.fcs_ok)
                good_next = sat_inc(good_reg);
            if (drone)
            begin
                beacons_next = sat_inc(beacons_reg);
                if (!first_valid_reg)
                begin
                    first_mac_next   = mac_next;
                    first_valid_next = 1'b1;
                end
            end
            out_valid_next              = 1'b1;
            out_beat_next.frame_good    = frame_beat.fcs_ok;
            out_beat_next.drone_beacon  = drone;
            out_beat_next.source_mac    = mac_next;
            out_beat_next.same_as_first = drone && (mac_next == ref_mac);
            out_beat_next.frame_count   = frames_next;
            out_beat_next.good_count    = good_next;
            out_beat_next.beacon_count  = beacons_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            fc_ok_reg       <= 1'b0;
            id_zero_reg     <= 1'b0;
            ssid_len_reg    <= '0;
            ssid_ended_reg  <= 1'b0;
            phase_reg       <= PHASE_IDLE;
            found_reg       <= 1'b0;
            mac_reg         <= '0;
            first_mac_reg   <= '0;
            first_valid_reg <= 1'b0;
            frames_reg      <= '0;
            good_reg        <= '0;
            beacons_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (end_beat)
            begin
                pos_reg        <= '0;
                fc_ok_reg      <= 1'b0;
                id_zero_reg    <= 1'b0;
                ssid_len_reg   <= '0;
                ssid_ended_reg <= 1'b0;
                phase_reg      <= PHASE_IDLE;
                found_reg      <= 1'b0;
                mac_reg        <= '0;
            end
            else if (accept)
            begin
                pos_reg        <= pos_next;
                fc_ok_reg      <= fc_ok_next;
                id_zero_reg    <= id_zero_next;
                ssid_len_reg   <= ssid_len_next;
                ssid_ended_reg <= ssid_ended_next;
                phase_reg      <= phase_next;
                found_reg      <= found_next;
                mac_reg        <= mac_next;
            end
            first_mac_reg   <= first_mac_next;
            first_valid_reg <= first_valid_next;
            frames_reg      <= frames_next;
            good_reg        <= good_next;
            beacons_reg     <= beacons_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

endmodule

`default_nettype wire

@@ rtl/dbff_checker.sv @@
// port-level checker for the drone beacon frame filter, bound to the top level
`default_nettype none

module dbff_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  frame_valid,
    input wire                  frame_ready,
    input dbff_pkg::in_beat_t   frame_beat,
    input wire                  result_valid,
    input wire                  result_ready,
    input dbff_pkg::out_beat_t  result_beat
);
    import dbff_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_beat))
        else $error("result beat changed while stalled");

    // input is only held off by a full, undrained result register
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid || result_ready |-> frame_ready)
        else $error("frame_ready low with room for a result");

    // a last byte shows up as a result on the next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && frame_beat.last_byte |=> result_valid)
        else $error("no result after last byte");

    a_flag_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result_beat.drone_beacon || result_beat.frame_good) &&
                         (!result_beat.same_as_first || result_beat.drone_beacon))
        else $error("result flags inconsistent");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_beat.good_count <= result_beat.frame_count) &&
                         (result_beat.beacon_count <= result_beat.good_count))
        else $error("counters out of order");

endmodule

bind drone_beacon_frame_filter dbff_checker u_dbff_checker (.*);

`default_nettype wire
